// ----- design/afc_pkg.sv -----
// Shared types, constants and the CRC byte update for the acknowledge frame checker.
package afc_pkg;

  localparam int unsigned PosW = 17;

  localparam logic [7:0]  START_BYTE0 = 8'h55;
  localparam logic [7:0]  START_BYTE1 = 8'h66;
  localparam logic [7:0]  ACK_MASK    = 8'h02;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_TOP     = 16'h8000;
  localparam logic [7:0]  ATT_COMMAND = 8'h0D;
  localparam logic [15:0] ATT_MIN_LEN = 16'd12;
  localparam logic [PosW-1:0] HEADER_LEN = 17'd8;

  // Byte positions inside the frame
  localparam logic [PosW-1:0] POS_START0  = 17'd0;
  localparam logic [PosW-1:0] POS_START1  = 17'd1;
  localparam logic [PosW-1:0] POS_CTRL    = 17'd2;
  localparam logic [PosW-1:0] POS_LEN_LO  = 17'd3;
  localparam logic [PosW-1:0] POS_LEN_HI  = 17'd4;
  localparam logic [PosW-1:0] POS_COMMAND = 17'd7;
  localparam logic [PosW-1:0] POS_YAW_LO  = 17'd8;
  localparam logic [PosW-1:0] POS_YAW_HI  = 17'd9;
  localparam logic [PosW-1:0] POS_PIT_LO  = 17'd10;
  localparam logic [PosW-1:0] POS_PIT_HI  = 17'd11;
  localparam logic [PosW-1:0] POS_ROL_LO  = 17'd12;
  localparam logic [PosW-1:0] POS_ROL_HI  = 17'd13;
  // last byte at this position or later means the frame holds at least 10 bytes
  localparam logic [PosW-1:0] POS_MIN_LAST = 17'd9;
  localparam logic [PosW-1:0] POS_MAX      = 17'h1FFFF;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_START = 3'd2,
    ST_NOT_ACK   = 3'd3,
    ST_TRUNCATED = 3'd4,
    ST_CRC_BAD   = 3'd5
  } afc_status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } afc_in_t;

  typedef struct packed {
    afc_status_e        status;
    logic [7:0]         command;
    logic               attitude_valid;
    logic signed [15:0] yaw_tenths;
    logic signed [15:0] pitch_tenths;
    logic signed [15:0] roll_tenths;
  } afc_out_t;

  // CRC16-XMODEM, one byte folded in per call
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- design/afc_parser.sv -----
// Frame state: position tracking, header capture, CRC and the per-frame verdict.
module afc_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  afc_pkg::afc_in_t  item_i,
  output afc_pkg::afc_out_t result_o
);
  import afc_pkg::*;

  logic [PosW-1:0] pos_q;
  logic            start_ok_q, start_ok_d;
  logic            ack_q, ack_d;
  logic [15:0]     len_q, len_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [15:0]     crc_q, crc_d;
  logic [15:0]     rx_crc_q, rx_crc_d;
  logic [15:0]     yaw_q, yaw_d;
  logic [15:0]     pit_q, pit_d;
  logic [15:0]     rol_q, rol_d;
  logic [PosW-1:0] crc_end;
  logic [7:0]      b;
  afc_status_e     status;
  logic            att;

  assign b = item_i.rx_byte;

  always_comb begin
    start_ok_d = start_ok_q;
    ack_d      = ack_q;
    len_d      = len_q;
    cmd_d      = cmd_q;
    yaw_d      = yaw_q;
    pit_d      = pit_q;
    rol_d      = rol_q;
    case (pos_q)
      POS_START0:  if (b != START_BYTE0) start_ok_d = 1'b0;
      POS_START1:  if (b != START_BYTE1) start_ok_d = 1'b0;
      POS_CTRL:    ack_d = (b & ACK_MASK) != 8'h00;
      POS_LEN_LO:  len_d = {len_q[15:8], b};
      POS_LEN_HI:  len_d = {b, len_q[7:0]};
      POS_COMMAND: cmd_d = b;
      POS_YAW_LO:  yaw_d = {yaw_q[15:8], b};
      POS_YAW_HI:  yaw_d = {b, yaw_q[7:0]};
      POS_PIT_LO:  pit_d = {pit_q[15:8], b};
      POS_PIT_HI:  pit_d = {b, pit_q[7:0]};
      POS_ROL_LO:  rol_d = {rol_q[15:8], b};
      POS_ROL_HI:  rol_d = {b, rol_q[7:0]};
      default: ;
    endcase
  end

  // crc_end is never below the header length, so one compare covers the header too
  assign crc_end = HEADER_LEN + {1'b0, len_d};

  always_comb begin
    crc_d    = crc_q;
    rx_crc_d = rx_crc_q;
    if (pos_q < crc_end) begin
      crc_d = crc_step(crc_q, b);
    end else if (pos_q == crc_end) begin
      rx_crc_d = {rx_crc_q[15:8], b};
    end else if (pos_q == crc_end + 17'd1) begin
      rx_crc_d = {b, rx_crc_q[7:0]};
    end
  end

  always_comb begin
    if (pos_q < POS_MIN_LAST) begin
      status = ST_SHORT;
    end else if (!start_ok_d) begin
      status = ST_BAD_START;
    end else if (!ack_d) begin
      status = ST_NOT_ACK;
    end else if (pos_q <= crc_end) begin
      // CRC high byte not yet seen
      status = ST_TRUNCATED;
    end else if (crc_d != rx_crc_d) begin
      status = ST_CRC_BAD;
    end else begin
      status = ST_ACCEPTED;
    end
  end

  assign att = (status == ST_ACCEPTED) && (cmd_d == ATT_COMMAND) && (len_d >= ATT_MIN_LEN);

  always_comb begin
    result_o.status         = status;
    result_o.command        = (pos_q >= POS_COMMAND) ? cmd_d : 8'h00;
    result_o.attitude_valid = att;
    result_o.yaw_tenths     = att ? yaw_d : 16'h0000;
    result_o.pitch_tenths   = att ? pit_d : 16'h0000;
    result_o.roll_tenths    = att ? rol_d : 16'h0000;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      start_ok_q <= 1'b1;
      ack_q      <= 1'b0;
      len_q      <= '0;
      cmd_q      <= '0;
      crc_q      <= '0;
      rx_crc_q   <= '0;
      yaw_q      <= '0;
      pit_q      <= '0;
      rol_q      <= '0;
    end else if (step_i) begin
      if (item_i.last_byte) begin
        pos_q      <= '0;
        start_ok_q <= 1'b1;
        ack_q      <= 1'b0;
        len_q      <= '0;
        cmd_q      <= '0;
        crc_q      <= '0;
        rx_crc_q   <= '0;
        yaw_q      <= '0;
        pit_q      <= '0;
        rol_q      <= '0;
      end else begin
        if (pos_q != POS_MAX) pos_q <= pos_q + 17'd1;
        start_ok_q <= start_ok_d;
        ack_q      <= ack_d;
        len_q      <= len_d;
        cmd_q      <= cmd_d;
        crc_q      <= crc_d;
        rx_crc_q   <= rx_crc_d;
        yaw_q      <= yaw_d;
        pit_q      <= pit_d;
        rol_q      <= rol_d;
      end
    end
  end

endmodule

// ----- design/ack_frame_checker.sv -----
// Acknowledge frame checker top level: input register, frame parser, result register.
//
// Bytes of a datagram arrive one per request on the input channel, in order, with
// last_byte set on the final byte. Exactly one result leaves on the output channel
// per datagram: status, command and, for a good attitude reply, yaw, pitch and roll.
// Bytes without last_byte produce nothing on the output.
// Both channels move a request at a clock edge where valid is high and stall low.
// Throughput: one byte per cycle while no last byte waits; the CRC update is an 8-bit
// unrolled step, so the parser folds each byte in straight from the input register.
// out_valid_o rises at the edge where the last byte leaves the input register.
// A finished result waits in the output register; bytes that are not the last keep
// flowing while it waits. A last byte waits in the input register until the output
// register frees, and in_stall_o stays high while it waits.
// Reset empties both registers and clears the frame state; the first byte after reset
// is taken as position 0 of a new datagram.
module ack_frame_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  afc_pkg::afc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output afc_pkg::afc_out_t out_data_o
);
  import afc_pkg::*;

  logic     in_valid_q;
  afc_in_t  in_q;
  logic     out_valid_q;
  afc_out_t out_q;
  afc_out_t result;
  logic     fire;

  // A byte may move on unless it produces a result and the result slot is held
  assign fire       = in_valid_q && (!in_q.last_byte || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;

  afc_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (fire),
    .item_i  (in_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire && in_q.last_byte) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_q <= in_data_i;
    if (fire && in_q.last_byte) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- design/afc_checker.sv -----
// Port-level checks for the acknowledge frame checker, bound to the top level.
module afc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input afc_pkg::afc_out_t out_data_o
);
  import afc_pkg::*;

  // A held result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // With the result slot empty nothing can block the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.attitude_valid |->
      out_data_o.status == ST_ACCEPTED && out_data_o.command == ATT_COMMAND)
    else $error("attitude flagged on a frame that is not a good attitude reply");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.attitude_valid |->
      out_data_o.yaw_tenths == 16'sd0 && out_data_o.pitch_tenths == 16'sd0 &&
      out_data_o.roll_tenths == 16'sd0)
    else $error("angles nonzero without attitude");

  // Status codes above the CRC mismatch never occur
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= ST_CRC_BAD)
    else $error("status code out of range");

endmodule

bind ack_frame_checker afc_checker u_afc_checker (.*);
